>>> rtl/rwbs_pkg.sv
// shared constants for the roulette wheel bisection select block
`timescale 1ns / 1ps
`default_nettype none

package rwbs_pkg;

    // port field widths
    localparam int FUNC_W  = 1;
    localparam int ENTRY_W = 8;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 9;
    localparam int OUT_W   = 8;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SELECT = 1'b1;

endpackage : rwbs_pkg

`default_nettype wire

>>> rtl/rwbs_front.sv
// front end: accepts items, drops out of range writes, builds queue entries
`timescale 1ns / 1ps
`default_nettype none

module rwbs_front
    import rwbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int WEIGHT_BITS = 32,
    parameter int IDX_W       = 8
)
(
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [FUNC_W-1:0]      func,
    input  wire logic [ENTRY_W-1:0]     entry_index,
    input  wire logic [VALUE_W-1:0]     value,
    input  wire logic [CFG_W-1:0]       entries_in_use,
    input  wire logic                   q_full,
    output logic                        q_push,
    output logic [FUNC_W-1:0]           q_func,
    output logic [IDX_W-1:0]            q_idx,
    output logic [WEIGHT_BITS-1:0]      q_weight
);

    logic [31:0] eiu_w;
    logic [IDX_W-1:0] last_idx;
    logic write_ok;

    // last searched entry after the zero and saturation rules
    always_comb
    begin
        eiu_w = 32'(entries_in_use);
        if (eiu_w == 32'd0)
        begin
            last_idx = '0;
        end
        else if (eiu_w > 32'(TABLE_DEPTH))
        begin
            last_idx = IDX_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_idx = IDX_W'(eiu_w - 32'd1);
        end
    end

    assign write_ok = (32'(entry_index) < 32'(TABLE_DEPTH));

    assign full     = q_full;
    // a write outside the table is taken and dropped here
    assign q_push   = push && !q_full && ((func == FUNC_SELECT) || write_ok);
    assign q_func   = func;
    assign q_idx    = (func == FUNC_SELECT) ? last_idx : IDX_W'(entry_index);
    assign q_weight = WEIGHT_BITS'(value);

endmodule : rwbs_front

`default_nettype wire

>>> rtl/rwbs_fifo.sv
// two entry queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module rwbs_fifo
#(
    parameter int DATA_W = 41
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   is_full,
    input  wire logic              rd_en,
    output logic                   rd_valid,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0] slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign is_full  = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule : rwbs_fifo

`default_nettype wire

>>> rtl/rwbs_back.sv
// back end: weight table, bisection sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

module rwbs_back
    import rwbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int WEIGHT_BITS = 32,
    parameter int IDX_W       = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire logic [FUNC_W-1:0]      q_func,
    input  wire logic [IDX_W-1:0]       q_idx,
    input  wire logic [WEIGHT_BITS-1:0] q_weight,
    output logic                        q_pop,
    input  wire logic                   pop,
    output logic                        empty,
    output logic [OUT_W-1:0]            chosen_index
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic [WEIGHT_BITS-1:0] mem [TABLE_DEPTH];
    logic [WEIGHT_BITS-1:0] rdata_reg;
    logic [IDX_W-1:0]       rd_addr;

    logic                   state_reg;
    logic                   state_next;
    logic [IDX_W-1:0]       low_reg;
    logic [IDX_W-1:0]       low_next;
    logic [IDX_W-1:0]       high_reg;
    logic [IDX_W-1:0]       high_next;
    logic [IDX_W-1:0]       mid_reg;
    logic [IDX_W-1:0]       mid_next;
    logic [WEIGHT_BITS-1:0] draw_reg;
    logic [WEIGHT_BITS-1:0] draw_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [IDX_W-1:0]       out_idx_reg;
    logic [IDX_W-1:0]       out_idx_next;

    logic             is_sel;
    logic             take;
    logic             mem_we;
    logic             above;
    logic [IDX_W-1:0] step_low;
    logic [IDX_W-1:0] step_high;
    logic [IDX_W:0]   step_sum;
    logic [IDX_W-1:0] step_mid;
    logic [IDX_W-1:0] first_mid;

    assign is_sel = (q_func == FUNC_SELECT);
    // a select waits until the result register is free
    assign take   = (state_reg == ST_IDLE) && q_valid && (!is_sel || !out_valid_reg);
    assign q_pop  = take;
    assign mem_we = take && !is_sel;

    assign first_mid = q_idx >> 1;

    // one bisection step on the entry read last cycle
    always_comb
    begin
        above     = (rdata_reg > draw_reg);
        step_low  = above ? low_reg : mid_reg;
        step_high = above ? mid_reg : high_reg;
        step_sum  = {1'b0, step_low} + {1'b0, step_high};
        step_mid  = step_sum[IDX_W:1];
    end

    assign rd_addr = (state_reg == ST_SEARCH) ? step_mid : first_mid;

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        draw_next      = draw_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && is_sel)
                begin
                    low_next  = '0;
                    high_next = q_idx;
                    mid_next  = first_mid;
                    draw_next = q_weight;
                    if (first_mid == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                low_next  = step_low;
                high_next = step_high;
                mid_next  = step_mid;
                if (step_mid == step_low)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = step_low;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg     <= low_next;
        high_reg    <= high_next;
        mid_reg     <= mid_next;
        draw_reg    <= draw_next;
        out_idx_reg <= out_idx_next;
    end

    // weight table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_idx] <= q_weight;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign empty        = !out_valid_reg;
    assign chosen_index = OUT_W'(out_idx_reg);

endmodule : rwbs_back

`default_nettype wire

>>> rtl/roulette_wheel_bisection_select.sv
// top level of the roulette wheel bisection select block
// usage:
//   input channel: push/full; a beat is taken when push is high and full low.
//   func selects a table write (entry_index, value = cumulative weight) or a
//   select (value = random draw below the total weight).
//   result channel: empty/pop; chosen_index shows the oldest result while
//   empty is low, and a beat leaves when pop is high and empty low.
//   writes give no result beat, each select gives exactly one.
//   config channel: cfg_valid/cfg_ready carries entries_in_use; cfg_ready is
//   always high, write it only while the block is idle.
// queue and search:
//   a beat is registered in the two entry front queue, then the back end
//   takes it once idle, and writes the table as it takes a write. a select
//   runs one bisection step per table read, ceil(log2(entries searched))
//   steps at most, since each step reads one table entry through the single
//   registered read port; no new beat is taken while a select searches.
// reset: queue and result register empty, entries_in_use back to 1. the
//   weight table is not cleared; a select must only touch written entries.
// stalls: a waiting result holds while pop is low; the back end keeps doing
//   writes but holds the next select, and full rises once the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module roulette_wheel_bisection_select
    import rwbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int WEIGHT_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input item channel
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [FUNC_W-1:0]    func,
    input  wire logic [ENTRY_W-1:0]   entry_index,
    input  wire logic [VALUE_W-1:0]   value,
    // result channel
    output logic                      empty,
    input  wire logic                 pop,
    output logic [OUT_W-1:0]          chosen_index,
    // configuration channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    // queue entry: function, index or last entry, weight or draw
    localparam int DATA_W = FUNC_W + IDX_W + WEIGHT_BITS;

    logic [CFG_W-1:0] eiu_reg;
    logic [CFG_W-1:0] eiu_next;

    logic                   q_full;
    logic                   q_push;
    logic [FUNC_W-1:0]      f_func;
    logic [IDX_W-1:0]       f_idx;
    logic [WEIGHT_BITS-1:0] f_weight;
    logic                   q_valid;
    logic                   q_pop;
    logic [DATA_W-1:0]      q_rd_data;
    logic [FUNC_W-1:0]      b_func;
    logic [IDX_W-1:0]       b_idx;
    logic [WEIGHT_BITS-1:0] b_weight;

    // configuration register, always ready
    assign cfg_ready = 1'b1;
    assign eiu_next  = (cfg_valid && cfg_ready) ? cfg_data : eiu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eiu_reg <= CFG_W'(1);
        end
        else
        begin
            eiu_reg <= eiu_next;
        end
    end

    rwbs_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS),
        .IDX_W       (IDX_W)
    ) u_front (
        .push           (push),
        .full           (full),
        .func           (func),
        .entry_index    (entry_index),
        .value          (value),
        .entries_in_use (eiu_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_func         (f_func),
        .q_idx          (f_idx),
        .q_weight       (f_weight)
    );

    rwbs_fifo #(
        .DATA_W (DATA_W)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  ({f_func, f_idx, f_weight}),
        .is_full  (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    assign {b_func, b_idx, b_weight} = q_rd_data;

    rwbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS),
        .IDX_W       (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_func       (b_func),
        .q_idx        (b_idx),
        .q_weight     (b_weight),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .chosen_index (chosen_index)
    );

endmodule : roulette_wheel_bisection_select

`default_nettype wire

>>> rtl/rwbs_checker.sv
// port level checks for the roulette wheel bisection select block
`timescale 1ns / 1ps
`default_nettype none

module rwbs_checker
    import rwbs_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             push,
    input wire logic             full,
    input wire logic             empty,
    input wire logic             pop,
    input wire logic [OUT_W-1:0] chosen_index,
    input wire logic             cfg_valid,
    input wire logic             cfg_ready
);

    // no result beat is pending while reset is held
    a_empty_in_reset: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result pending during reset");

    // a waiting result beat holds its value until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(chosen_index)))
        else $error("waiting result changed");

    // the queue only fills through an accepted input beat
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a push");

    // the config channel never refuses a beat
    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config beat refused");

endmodule : rwbs_checker

bind roulette_wheel_bisection_select rwbs_checker u_rwbs_checker (.*);

`default_nettype wire
